/* rtl/core/tpse_pkg.sv */
package tpse_pkg;

    localparam int NORM_BITS     = 24;
    localparam int POS_FRAC_BITS = 8;
    localparam int WIDTH_BITS    = 10;
    localparam int RGBA_BITS     = 32;
    localparam int HALF_BITS     = WIDTH_BITS - 1;
    localparam int ROOT_STEPS    = NORM_BITS + 1;
    localparam int ROOT_BITS     = NORM_BITS + 1;
    localparam int RAD_BITS      = 2 * ROOT_STEPS;
    localparam int REM_BITS      = ROOT_BITS + 3;
    localparam int DREM_BITS     = ROOT_BITS + 2;
    localparam int MAG_BITS      = 18;
    localparam int CNT_BITS      = 5;

    localparam logic REQ_CLEAR = 1'b1;

    // datapath commands, one per controller step
    typedef struct packed {
        logic       first;
        logic       load;
        logic       commit;
        logic       norm;
        logic       sq;
        logic       sum;
        logic       root;
        logic       dset;
        logic       div;
        logic       qclr;
        logic       offs;
        logic       emit;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic zero;
    } t_status;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_NORM = 9'b000000010,
        ST_SQ   = 9'b000000100,
        ST_SUM  = 9'b000001000,
        ST_ROOT = 9'b000010000,
        ST_DSET = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_OFFS = 9'b010000000,
        ST_EMIT = 9'b100000000
    } t_state;

endpackage

/* rtl/core/tpse_pt_if.sv */
interface tpse_pt_if #(
    parameter int COORD_WIDTH = 24
);
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic signed [COORD_WIDTH-1:0]        point_x;
    logic signed [COORD_WIDTH-1:0]        point_y;
    logic [tpse_pkg::WIDTH_BITS-1:0]      width;
    logic [tpse_pkg::RGBA_BITS-1:0]       rgba;

    modport source (output valid, req_type, point_x, point_y, width, rgba, input ready);
    modport sink   (input valid, req_type, point_x, point_y, width, rgba, output ready);
endinterface

/* rtl/core/tpse_vtx_if.sv */
interface tpse_vtx_if #(
    parameter int COORD_WIDTH = 24
);
    logic                                 valid;
    logic                                 ready;
    logic signed [COORD_WIDTH-1:0]        vertex_x;
    logic signed [COORD_WIDTH-1:0]        vertex_y;
    logic [tpse_pkg::RGBA_BITS-1:0]       vertex_rgba;
    logic                                 last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_rgba, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_rgba, last_vertex, output ready);
endinterface

/* rtl/core/tpse_ctrl.sv */
module tpse_ctrl #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_req,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tpse_pkg::t_status  i_status,
    output tpse_pkg::t_cmd     o_cmd
);
    tpse_pkg::t_state r_state, n_state;
    logic [tpse_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic [1:0] r_idx, n_idx;
    logic r_have, n_have;
    logic r_oval, n_oval;
    logic accept;

    assign o_in_ready  = (r_state == tpse_pkg::ST_IDLE);
    assign o_out_valid = r_oval;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_have  = r_have;
        n_oval  = i_out_ready ? 1'b0 : r_oval;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            tpse_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in_req == tpse_pkg::REQ_CLEAR) begin
                        n_have = 1'b0;
                    end else if (r_have) begin
                        o_cmd.load = 1'b1;
                        n_state = tpse_pkg::ST_NORM;
                    end else begin
                        o_cmd.first = 1'b1;
                        n_have = 1'b1;
                    end
                end
            end
            tpse_pkg::ST_NORM: begin
                if (i_status.zero) begin
                    o_cmd.qclr = 1'b1;
                    n_idx = '0;
                    n_state = tpse_pkg::ST_OFFS;
                end else if (i_status.norm_done) begin
                    n_state = tpse_pkg::ST_SQ;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            tpse_pkg::ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = tpse_pkg::ST_SUM;
            end
            tpse_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt = '0;
                n_state = tpse_pkg::ST_ROOT;
            end
            tpse_pkg::ST_ROOT: begin
                o_cmd.root = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tpse_pkg::CNT_BITS'(tpse_pkg::ROOT_STEPS - 1)) begin
                    n_state = tpse_pkg::ST_DSET;
                end
            end
            tpse_pkg::ST_DSET: begin
                o_cmd.dset = 1'b1;
                n_cnt = '0;
                n_state = tpse_pkg::ST_DIV;
            end
            tpse_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tpse_pkg::CNT_BITS'(UNIT_FRAC_BITS)) begin
                    n_idx = '0;
                    n_state = tpse_pkg::ST_OFFS;
                end
            end
            tpse_pkg::ST_OFFS: begin
                o_cmd.offs = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == 2'd3) begin
                    n_state = tpse_pkg::ST_EMIT;
                end
            end
            tpse_pkg::ST_EMIT: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_oval = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        o_cmd.commit = 1'b1;
                        n_state = tpse_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = tpse_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpse_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_have  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_have  <= n_have;
            r_oval  <= n_oval;
        end
    end
endmodule

/* rtl/core/tpse_dp.sv */
module tpse_dp #(
    parameter int COORD_WIDTH    = 24,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  tpse_pkg::t_cmd                      i_cmd,
    output tpse_pkg::t_status                   o_status,
    input  logic signed [COORD_WIDTH-1:0]       i_point_x,
    input  logic signed [COORD_WIDTH-1:0]       i_point_y,
    input  logic [tpse_pkg::WIDTH_BITS-1:0]     i_width,
    input  logic [tpse_pkg::RGBA_BITS-1:0]      i_rgba,
    output logic signed [COORD_WIDTH-1:0]       o_vertex_x,
    output logic signed [COORD_WIDTH-1:0]       o_vertex_y,
    output logic [tpse_pkg::RGBA_BITS-1:0]      o_vertex_rgba,
    output logic                                o_last_vertex
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int NW   = (DW > tpse_pkg::NORM_BITS) ? DW : tpse_pkg::NORM_BITS;
    localparam int QW   = UNIT_FRAC_BITS + 1;
    localparam int PW   = tpse_pkg::HALF_BITS + QW + tpse_pkg::POS_FRAC_BITS;
    localparam int SW   = ((COORD_WIDTH > tpse_pkg::MAG_BITS) ? COORD_WIDTH
                                                             : tpse_pkg::MAG_BITS) + 2;
    localparam int NB   = tpse_pkg::NORM_BITS;
    localparam int RB   = tpse_pkg::ROOT_BITS;
    localparam int RADW = tpse_pkg::RAD_BITS;
    localparam int REMW = tpse_pkg::REM_BITS;
    localparam int DRW  = tpse_pkg::DREM_BITS;
    localparam int MW   = tpse_pkg::MAG_BITS;

    logic signed [COORD_WIDTH-1:0] r_px, r_py, r_cx, r_cy;
    logic [tpse_pkg::WIDTH_BITS-1:0] r_pw, r_cw;
    logic [tpse_pkg::RGBA_BITS-1:0]  r_pc, r_cc;
    logic r_dxn, r_dyn;
    logic [NW-1:0] r_ax, r_ay;
    logic [2*NB-1:0] r_sqx, r_sqy;
    logic [RADW-1:0] r_rad;
    logic [REMW-1:0] r_rem;
    logic [RB-1:0]   r_root;
    logic [DRW-1:0]  r_drx, r_dry;
    logic [QW-1:0]   r_qx, r_qy;
    logic [MW-1:0]   r_mag [4];

    logic signed [DW-1:0] dx, dy;
    logic [NW-1:0] m;
    logic [REMW-1:0] rem_sh, trial;
    logic [DRW-1:0] nd;
    logic [tpse_pkg::HALF_BITS-1:0] half;
    logic [QW-1:0] qsel;
    logic [PW-1:0] prod;
    logic signed [COORD_WIDTH-1:0] ptx, pty;
    logic negx, negy;
    logic signed [SW-1:0] sx, sy, hi_lim, lo_lim;

    assign dx = DW'(i_point_x) - DW'(r_px);
    assign dy = DW'(i_point_y) - DW'(r_py);

    assign m = (r_ax > r_ay) ? r_ax : r_ay;
    assign o_status.zero      = (m == '0);
    assign o_status.norm_done = ((m >> NB) == '0) && m[NB-1];

    assign rem_sh = {r_rem[REMW-3:0], r_rad[RADW-1 -: 2]};
    assign trial  = REMW'({r_root, 2'b01});
    assign nd     = DRW'(r_root);

    // k[1] picks the point, k[0]: x offset from |uy|, y offset from |ux|
    assign half = i_cmd.idx[1] ? r_cw[tpse_pkg::WIDTH_BITS-1:1] : r_pw[tpse_pkg::WIDTH_BITS-1:1];
    assign qsel = i_cmd.idx[0] ? r_qx : r_qy;
    assign prod = (PW'(half) * PW'(qsel)) << tpse_pkg::POS_FRAC_BITS;

    assign ptx  = i_cmd.idx[1] ? r_cx : r_px;
    assign pty  = i_cmd.idx[1] ? r_cy : r_py;
    // perpendicular (-uy, ux); minus vertex flips both
    assign negx = !r_dyn ^ i_cmd.idx[0];
    assign negy = r_dxn ^ i_cmd.idx[0];

    always_comb begin
        logic [SW-1:0] mx, my;
        mx = SW'(r_mag[{i_cmd.idx[1], 1'b0}]);
        my = SW'(r_mag[{i_cmd.idx[1], 1'b1}]);
        sx = SW'(ptx) + (negx ? -mx : mx);
        sy = SW'(pty) + (negy ? -my : my);
    end

    assign hi_lim = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    assign lo_lim = -hi_lim - SW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.first || i_cmd.commit) begin
            r_px <= i_cmd.first ? i_point_x : r_cx;
            r_py <= i_cmd.first ? i_point_y : r_cy;
            r_pw <= i_cmd.first ? i_width   : r_cw;
            r_pc <= i_cmd.first ? i_rgba    : r_cc;
        end
        if (i_cmd.load) begin
            r_cx  <= i_point_x;
            r_cy  <= i_point_y;
            r_cw  <= i_width;
            r_cc  <= i_rgba;
            r_dxn <= dx[DW-1];
            r_dyn <= dy[DW-1];
            r_ax  <= NW'(dx[DW-1] ? -dx : dx);
            r_ay  <= NW'(dy[DW-1] ? -dy : dy);
        end
        if (i_cmd.norm) begin
            if ((m >> NB) != '0) begin
                r_ax <= r_ax >> 1;
                r_ay <= r_ay >> 1;
            end else begin
                r_ax <= r_ax << 1;
                r_ay <= r_ay << 1;
            end
        end
        if (i_cmd.sq) begin
            r_sqx <= r_ax[NB-1:0] * r_ax[NB-1:0];
            r_sqy <= r_ay[NB-1:0] * r_ay[NB-1:0];
        end
        if (i_cmd.sum) begin
            r_rad  <= RADW'(r_sqx) + RADW'(r_sqy);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root) begin
            r_rad <= r_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RB-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RB-2:0], 1'b0};
            end
        end
        if (i_cmd.dset) begin
            r_drx <= DRW'(r_ax[NB-1:0]);
            r_dry <= DRW'(r_ay[NB-1:0]);
            r_qx  <= '0;
            r_qy  <= '0;
        end
        if (i_cmd.div) begin
            if (r_drx >= nd) begin
                r_drx <= (r_drx - nd) << 1;
                r_qx  <= {r_qx[QW-2:0], 1'b1};
            end else begin
                r_drx <= r_drx << 1;
                r_qx  <= {r_qx[QW-2:0], 1'b0};
            end
            if (r_dry >= nd) begin
                r_dry <= (r_dry - nd) << 1;
                r_qy  <= {r_qy[QW-2:0], 1'b1};
            end else begin
                r_dry <= r_dry << 1;
                r_qy  <= {r_qy[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.qclr) begin
            r_qx <= '0;
            r_qy <= '0;
        end
        if (i_cmd.offs) begin
            r_mag[i_cmd.idx] <= MW'(prod >> UNIT_FRAC_BITS);
        end
        if (i_cmd.emit) begin
            o_vertex_x    <= (sx > hi_lim) ? COORD_WIDTH'(hi_lim) :
                             (sx < lo_lim) ? COORD_WIDTH'(lo_lim) : COORD_WIDTH'(sx);
            o_vertex_y    <= (sy > hi_lim) ? COORD_WIDTH'(hi_lim) :
                             (sy < lo_lim) ? COORD_WIDTH'(lo_lim) : COORD_WIDTH'(sy);
            o_vertex_rgba <= i_cmd.idx[1] ? r_cc : r_pc;
            o_last_vertex <= (i_cmd.idx == 2'd3);
        end
    end
endmodule

/* rtl/core/thick_polyline_strip_expander.sv */
// Thick polyline strip expander.
// Input channel i_pt carries polyline points (Q15.8 x/y, stroke width, RGBA)
// or a clear request. Output channel o_vtx carries triangle-strip vertices.
// The first point after reset or a clear is only stored. Each later point
// yields four vertex words: previous point +/- half its width along the
// segment normal (previous colour), then the new point likewise; the fourth
// word has last_vertex set. A zero-length segment puts all four on the points.
// Steps: a point with a predecessor is normalised (up to 23 shifts), then
// passes the bit-serial square root (25 steps) and the two parallel
// restoring dividers (UNIT_FRAC_BITS + 1 steps) that share one divisor,
// and four offset products are formed before its first vertex word. A
// zero-length segment skips the square root and the dividers.
// The four words then leave one per cycle while the receiver takes them.
// One point is in flight at a time; i_pt.ready is high only when idle, so
// a clear request or a first point is taken and leaves the block idle.
// Reset (synchronous, active low) forgets the previous point and drops any
// pending vertex word. When the receiver stalls, the output register holds
// the word and the sequencer waits; nothing is lost.
module thick_polyline_strip_expander #(
    parameter int COORD_WIDTH    = 24,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tpse_pt_if.sink    i_pt,
    tpse_vtx_if.source o_vtx
);
    tpse_pkg::t_cmd    cmd;
    tpse_pkg::t_status status;

    // sequencer: owns handshakes, valid flags and step counts
    tpse_ctrl #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_in_req   (i_pt.req_type),
        .o_in_ready (i_pt.ready),
        .o_out_valid(o_vtx.valid),
        .i_out_ready(o_vtx.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic: normalise, square root, divide, offsets, saturate
    tpse_dp #(
        .COORD_WIDTH   (COORD_WIDTH),
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_point_x    (i_pt.point_x),
        .i_point_y    (i_pt.point_y),
        .i_width      (i_pt.width),
        .i_rgba       (i_pt.rgba),
        .o_vertex_x   (o_vtx.vertex_x),
        .o_vertex_y   (o_vtx.vertex_y),
        .o_vertex_rgba(o_vtx.vertex_rgba),
        .o_last_vertex(o_vtx.last_vertex)
    );
endmodule

/* rtl/core/tpse_chk.sv */
module tpse_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);
    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("vertex word dropped while stalled");

    a_last_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_last))
        else $error("last flag changed while stalled");

    // no new word straight out of idle: a segment always takes its steps first
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |=> !$rose(i_out_valid))
        else $error("vertex word raised straight from idle");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("vertex word valid after reset");
endmodule

bind thick_polyline_strip_expander tpse_chk u_tpse_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pt.valid),
    .i_in_ready (i_pt.ready),
    .i_out_valid(o_vtx.valid),
    .i_out_ready(o_vtx.ready),
    .i_out_last (o_vtx.last_vertex)
);
